[rtl/core/tcw_pkg.sv]
// shared types and constants of the text console writer
`default_nettype none
package tcw_pkg;

	localparam int DEF_COLS = 80;
	localparam int DEF_ROWS = 25;

	localparam int OPCODE_W = 2;
	localparam int CHAR_W   = 8;
	localparam int IDX_W    = 11;
	localparam int POS_W    = 11;
	localparam int COLOR_W  = 4;
	localparam int CELL_W   = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [CFG_IDX_W-1:0] CFG_FG = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG = 2'd1;

	localparam logic [COLOR_W-1:0] FG_RESET = 4'hF;
	localparam logic [COLOR_W-1:0] BG_RESET = 4'h0;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [CHAR_W-1:0]   char_code;
		logic [IDX_W-1:0]    cell_index;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [CHAR_W-1:0] cell_char;
		logic [CHAR_W-1:0] cell_attr;
	} rsp_t;

endpackage
`default_nettype wire

[rtl/core/tcw_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[rtl/core/text_console_writer.sv]
// text console: cursor control and screen store sequencing
// each scroll copies every row up by one row, then zeroes the bottom row
// requests do not overlap: a new request is taken only once the sequencer is idle again;
//   every cell update, row copy and clear goes through the single write port of the
//   screen ram
// clear screen zeroes every cell; after reset a clearing pass zeroes the screen while no
//   request is taken
`default_nettype none
module text_console_writer #(
	parameter int COLS = tcw_pkg::DEF_COLS,
	parameter int ROWS = tcw_pkg::DEF_ROWS
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cmd_valid,
	output logic                                cmd_stall,
	input  wire tcw_pkg::cmd_t                  cmd,
	output logic                                rsp_valid,
	input  wire logic                           rsp_stall,
	output tcw_pkg::rsp_t                       rsp,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tcw_pkg::COLOR_W-1:0]    cfg_data
);

	localparam int NCELLS = COLS * ROWS;
	localparam int AW = $clog2(NCELLS);
	localparam int CW = $clog2(COLS);
	localparam int RW = $clog2(ROWS);
	localparam int IW = (AW > tcw_pkg::IDX_W) ? AW + 1 : tcw_pkg::IDX_W + 1;
	localparam int PW = (AW > tcw_pkg::POS_W) ? AW : tcw_pkg::POS_W;
	localparam logic [AW-1:0] LAST_BASE = AW'((ROWS - 1) * COLS);
	localparam logic [AW-1:0] LAST_CELL = AW'(NCELLS - 1);
	localparam logic [AW-1:0] COLS_A    = AW'(COLS);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_RD   = 7'b0000010,
		ST_PUT  = 7'b0000100,
		ST_SCRL = 7'b0001000,
		ST_ZERO = 7'b0010000,
		ST_CLR  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	typedef struct packed {
		logic                        valid;
		logic                        from_mem;
		logic [AW-1:0]               addr;
		logic [tcw_pkg::CELL_W-1:0]  data;
	} wr_t;

	state_t state_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] ptr_q;
	logic [1:0] rem_q;
	logic adv_q;
	logic emit_q;
	logic rd_ok_s1;
	logic [tcw_pkg::COLOR_W-1:0] fg_q;
	logic [tcw_pkg::COLOR_W-1:0] bg_q;
	logic [tcw_pkg::CHAR_W-1:0] put_char_q;
	logic [tcw_pkg::CHAR_W-1:0] cell_char_q;
	logic [tcw_pkg::CHAR_W-1:0] cell_attr_q;
	logic rsp_valid_q;
	tcw_pkg::rsp_t rsp_q;

	wr_t wr_nxt;
	wr_t wr_s1;
	logic wr_valid_s1;

	logic cmd_take;
	logic rsp_busy;
	logic rsp_fire;
	logic col_last;
	logic row_last;
	logic put_scroll;
	logic [IW-1:0] idx_w;
	logic idx_ok;
	logic [AW-1:0] rd_addr;
	logic [tcw_pkg::CELL_W-1:0] rdata;
	logic [tcw_pkg::CELL_W-1:0] wdata;
	logic [PW-1:0] pos_w;

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign cfg_ready = 1'b1;

	// a waiting result holds the sequencer in its last state, not the input
	assign rsp_busy = rsp_valid_q && rsp_stall;
	assign rsp_fire = (state_q == ST_FIN) && emit_q && !rsp_busy;

	assign col_last   = (col_q == CW'(COLS - 1));
	assign row_last   = (row_q == RW'(ROWS - 1));
	assign put_scroll = adv_q && col_last && row_last;

	assign idx_w   = IW'(cmd.cell_index);
	assign idx_ok  = (idx_w < IW'(NCELLS));
	assign rd_addr = (state_q == ST_SCRL) ? ptr_q : idx_w[AW-1:0];

	// single write path: cell updates, row copies and zeroing all pass through here
	always_comb begin
		wr_nxt = '0;
		unique case (state_q)
			ST_PUT: begin
				wr_nxt.valid = 1'b1;
				wr_nxt.addr  = pos_q;
				wr_nxt.data  = {bg_q, fg_q, put_char_q};
			end
			ST_SCRL: begin
				wr_nxt.valid    = 1'b1;
				wr_nxt.from_mem = 1'b1;
				wr_nxt.addr     = ptr_q - COLS_A;
			end
			ST_ZERO, ST_CLR: begin
				wr_nxt.valid = 1'b1;
				wr_nxt.addr  = ptr_q;
			end
			default: begin
				wr_nxt = '0;
			end
		endcase
	end

	assign wdata = wr_s1.from_mem ? rdata : wr_s1.data;

	tcw_ram #(
		.WIDTH(tcw_pkg::CELL_W),
		.DEPTH(NCELLS)
	) u_screen (
		.clk  (clk),
		.we   (wr_valid_s1),
		.waddr(wr_s1.addr),
		.wdata(wdata),
		.raddr(rd_addr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_s1 <= 1'b0;
		end else begin
			wr_valid_s1 <= wr_nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		wr_s1 <= wr_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= tcw_pkg::FG_RESET;
			bg_q <= tcw_pkg::BG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == tcw_pkg::CFG_FG) begin
				fg_q <= cfg_data;
			end else if (cfg_index == tcw_pkg::CFG_BG) begin
				bg_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			col_q       <= '0;
			row_q       <= '0;
			pos_q       <= '0;
			ptr_q       <= '0;
			rem_q       <= '0;
			adv_q       <= 1'b0;
			emit_q      <= 1'b0;
			rd_ok_s1    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						emit_q <= 1'b1;
						unique case (cmd.opcode)
							tcw_pkg::OP_WRITE: begin
								unique case (cmd.char_code)
									tcw_pkg::CH_NL: begin
										col_q <= '0;
										if (row_last) begin
											pos_q   <= LAST_BASE;
											ptr_q   <= COLS_A;
											rem_q   <= '0;
											state_q <= ST_SCRL;
										end else begin
											row_q   <= row_q + RW'(1);
											pos_q   <= pos_q - AW'(col_q) + COLS_A;
											state_q <= ST_FIN;
										end
									end
									tcw_pkg::CH_CR: begin
										col_q   <= '0;
										pos_q   <= pos_q - AW'(col_q);
										state_q <= ST_FIN;
									end
									tcw_pkg::CH_BS: begin
										// at the origin the cursor stays put
										if (col_q != '0) begin
											col_q <= col_q - CW'(1);
											pos_q <= pos_q - AW'(1);
										end else if (row_q != '0) begin
											col_q <= CW'(COLS - 1);
											row_q <= row_q - RW'(1);
											pos_q <= pos_q - AW'(1);
										end
										adv_q   <= 1'b0;
										rem_q   <= '0;
										state_q <= ST_PUT;
									end
									tcw_pkg::CH_TAB: begin
										adv_q   <= 1'b1;
										rem_q   <= 2'd3;
										state_q <= ST_PUT;
									end
									default: begin
										adv_q   <= 1'b1;
										rem_q   <= '0;
										state_q <= ST_PUT;
									end
								endcase
							end
							tcw_pkg::OP_CLEAR: begin
								ptr_q   <= '0;
								state_q <= ST_CLR;
							end
							tcw_pkg::OP_READ: begin
								rd_ok_s1 <= idx_ok;
								state_q  <= ST_RD;
							end
							default: begin
								state_q <= ST_FIN;
							end
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_FIN;
				end
				ST_PUT: begin
					if (adv_q) begin
						if (col_last) begin
							col_q <= '0;
							if (row_last) begin
								pos_q <= LAST_BASE;
							end else begin
								row_q <= row_q + RW'(1);
								pos_q <= pos_q + AW'(1);
							end
						end else begin
							col_q <= col_q + CW'(1);
							pos_q <= pos_q + AW'(1);
						end
					end
					priority if (put_scroll) begin
						ptr_q   <= COLS_A;
						state_q <= ST_SCRL;
					end else if (rem_q != '0) begin
						rem_q   <= rem_q - 2'd1;
						state_q <= ST_PUT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_SCRL: begin
					if (ptr_q == LAST_CELL) begin
						ptr_q   <= LAST_BASE;
						state_q <= ST_ZERO;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_ZERO: begin
					if (ptr_q == LAST_CELL) begin
						if (rem_q != '0) begin
							rem_q   <= rem_q - 2'd1;
							state_q <= ST_PUT;
						end else begin
							state_q <= ST_FIN;
						end
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_CLR: begin
					if (ptr_q == LAST_CELL) begin
						col_q   <= '0;
						row_q   <= '0;
						pos_q   <= '0;
						state_q <= ST_FIN;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				ST_FIN: begin
					// the reset clearing pass ends here without a result
					if (!rsp_busy) begin
						emit_q  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cell_char_q <= '0;
			cell_attr_q <= '0;
			if (cmd.char_code == tcw_pkg::CH_TAB) begin
				put_char_q <= tcw_pkg::CH_SPACE;
			end else if (cmd.char_code == tcw_pkg::CH_BS) begin
				put_char_q <= tcw_pkg::CH_NUL;
			end else begin
				put_char_q <= cmd.char_code;
			end
		end
		if (state_q == ST_RD && rd_ok_s1) begin
			cell_char_q <= rdata[tcw_pkg::CHAR_W-1:0];
			cell_attr_q <= rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
		end
		if (rsp_fire) begin
			rsp_q.cursor_pos <= pos_w[tcw_pkg::POS_W-1:0];
			rsp_q.cell_char  <= cell_char_q;
			rsp_q.cell_attr  <= cell_attr_q;
		end
	end

	assign pos_w     = PW'(pos_q);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
